FILE: hw/rtl/frm_pkg.sv
// Shared widths, types, register codes and helpers of the frame-from-normal pipeline.
`timescale 1ns / 1ps
`default_nettype none
package frm_pkg;

   localparam int FRAC_BITS = 14;

   localparam int IN_W  = 16;                  // normal and heading components
   localparam int P1_W  = 2 * IN_W;            // n * h products
   localparam int W_W   = P1_W + 1;            // w = n x h
   localparam int U_W   = W_W + IN_W;          // u = w x n (and its products)
   localparam int MAG_W = U_W - 1;             // magnitude of any vector component
   localparam int RED_W = 31;                  // magnitude after range reduction
   localparam int SQ_W  = 2 * RED_W;
   localparam int S_W   = SQ_W + 2;            // sum of three squares
   localparam int SH_W  = $clog2(MAG_W - RED_W + 1);

   localparam int NSTEP = FRAC_BITS + 2;       // result digits, one per stage
   localparam int Q_W   = FRAC_BITS + 2;
   localparam int D_W   = SQ_W + 2 * FRAC_BITS + 2;
   localparam int T_W   = S_W + FRAC_BITS + 2;
   localparam int CMP_W = D_W + 4;
   localparam int OUT_W = 16;

   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   typedef logic signed [IN_W-1:0]  in_type;
   typedef logic signed [P1_W-1:0]  p1_type;
   typedef logic signed [W_W-1:0]   w_type;
   typedef logic signed [U_W-1:0]   u_type;
   typedef logic [MAG_W-1:0]        mag_type;
   typedef logic [RED_W-1:0]        red_type;
   typedef logic [SQ_W-1:0]         sq_type;
   typedef logic [S_W-1:0]          s_type;
   typedef logic [SH_W-1:0]         sh_type;
   typedef logic [D_W-1:0]          d_type;
   typedef logic [T_W-1:0]          t_type;
   typedef logic [Q_W-1:0]          q_type;
   typedef logic [CMP_W-1:0]        cmp_type;
   typedef logic signed [Q_W:0]     val_type;
   typedef logic signed [OUT_W-1:0] out_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_HEADING_X = 2'd0,
      REG_HEADING_Y = 2'd1,
      REG_HEADING_Z = 2'd2
   } csr_reg_type;

   localparam logic signed [IN_W-1:0] HEADING_X_RST = 16'sd16384;
   localparam logic signed [IN_W-1:0] HEADING_Y_RST = 16'sd0;
   localparam logic signed [IN_W-1:0] HEADING_Z_RST = 16'sd0;

   // clamp a signed result into the 16-bit output field
   function automatic out_type sat_out(input val_type v);
      logic signed [31:0] t;
      t = 32'(v);
      if (t > 32'sd32767) begin
         t = 32'sd32767;
      end else if (t < -32'sd32768) begin
         t = -32'sd32768;
      end
      return out_type'(t);
   endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/frm_req_if.sv
// Request channel: one surface normal per beat.
`timescale 1ns / 1ps
`default_nettype none
interface frm_req_if;
   logic                valid;
   logic                ready;
   frm_pkg::in_type     nrm_x;
   frm_pkg::in_type     nrm_y;
   frm_pkg::in_type     nrm_z;

   modport source (output valid, nrm_x, nrm_y, nrm_z, input ready);
   modport sink   (input valid, nrm_x, nrm_y, nrm_z, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/frm_rsp_if.sv
// Response channel: one rotation matrix and degenerate flag per beat.
`timescale 1ns / 1ps
`default_nettype none
interface frm_rsp_if;
   logic                valid;
   logic                ready;
   frm_pkg::out_type    rot_00;
   frm_pkg::out_type    rot_01;
   frm_pkg::out_type    rot_02;
   frm_pkg::out_type    rot_10;
   frm_pkg::out_type    rot_11;
   frm_pkg::out_type    rot_12;
   frm_pkg::out_type    rot_20;
   frm_pkg::out_type    rot_21;
   frm_pkg::out_type    rot_22;
   logic                degenerate;

   modport source (output valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
                   rot_20, rot_21, rot_22, degenerate, input ready);
   modport sink   (input valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
                   rot_20, rot_21, rot_22, degenerate, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/frame_from_normal_and_heading.sv
// Top level: orthonormal frame from a surface normal and a programmed heading.
`timescale 1ns / 1ps
`default_nettype none
// Usage
//   req_if  : one beat per surface normal (nrm_x/y/z, Q1.14, any length).
//   rsp_if  : one beat per normal: 3x3 rotation rot_rc in Q1.14 plus degenerate.
//             Column 0 is the heading projected off the normal, column 1 is
//             normal x column 0, column 2 the unit normal. Zero normal or a
//             heading parallel to it gives an all-zero matrix, degenerate = 1.
//   csr_*   : heading_x/y/z at indexes 0..2, written while the block is idle.
// Throughput: one beat per cycle, sustained, while rsp_if.ready stays high.
// Pipeline: FRAC_BITS + 11 register stages (FRAC_BITS is 14 for Q1.14):
//   4 stages of cross products, 4 of magnitude / reduction / squares / sum,
//   FRAC_BITS + 2 stages of the reciprocal-root digit search (one result bit
//   per stage), one output register.
// Reset: synchronous; empties the pipe and loads the heading (1, 0, 0).
// Back-pressure: every stage keeps a valid bit and loads only when it or
//   the stage after it is empty or moving, so bubbles collapse; req_if.ready
//   stays high while there is room anywhere in the pipe. A stalled beat holds.
module frame_from_normal_and_heading (
   input  wire logic                          clock,
   input  wire logic                          reset,
   frm_req_if.sink                            req_if,
   frm_rsp_if.source                          rsp_if,
   input  wire logic                          csr_wr_en,
   input  wire logic [frm_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [frm_pkg::CSR_DAT_W-1:0] csr_wdata
);

   localparam int FRONT0 = 0;
   localparam int PREP0  = 4;
   localparam int ROOT0  = 8;
   localparam int OUT_STG = ROOT0 + frm_pkg::NSTEP;
   localparam int NSTG    = OUT_STG + 1;

   // heading registers
   frm_pkg::in_type heading_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         heading_ff[0] <= frm_pkg::HEADING_X_RST;
         heading_ff[1] <= frm_pkg::HEADING_Y_RST;
         heading_ff[2] <= frm_pkg::HEADING_Z_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            frm_pkg::REG_HEADING_X: heading_ff[0] <= frm_pkg::in_type'(csr_wdata);
            frm_pkg::REG_HEADING_Y: heading_ff[1] <= frm_pkg::in_type'(csr_wdata);
            frm_pkg::REG_HEADING_Z: heading_ff[2] <= frm_pkg::in_type'(csr_wdata);
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   // valid bits and per-stage load enables; en[i] means stage i may load
   logic [NSTG-1:0] vld_ff;
   logic [NSTG:0]   en;

   assign en[NSTG] = rsp_if.ready;
   for (genvar i = 0; i < NSTG; i++) begin : g_en
      assign en[i] = !vld_ff[i] || en[i+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < NSTG; i++) begin
            if (en[i]) begin
               vld_ff[i] <= (i == 0) ? req_if.valid : vld_ff[(i == 0) ? 0 : i - 1];
            end
         end
      end
   end

   assign req_if.ready = en[0];

   // datapath
   frm_pkg::in_type n_req [3];
   frm_pkg::in_type n_fr  [3];
   frm_pkg::w_type  w_fr  [3];
   frm_pkg::u_type  u_fr  [3];
   frm_pkg::s_type  s_pr  [3];
   frm_pkg::sq_type sq_pr [3][3];
   logic            neg_pr [3][3];
   logic            zero_pr [3];
   frm_pkg::q_type  m_rt  [3][3];
   logic            neg_rt [3][3];
   logic            zero_rt [3];

   assign n_req[0] = req_if.nrm_x;
   assign n_req[1] = req_if.nrm_y;
   assign n_req[2] = req_if.nrm_z;

   frm_front u_front (
      .clock (clock),
      .en    (en[FRONT0 +: 4]),
      .n_in  (n_req),
      .h_in  (heading_ff),
      .n_out (n_fr),
      .w_out (w_fr),
      .u_out (u_fr)
   );

   frm_prep u_prep (
      .clock    (clock),
      .en       (en[PREP0 +: 4]),
      .n_in     (n_fr),
      .w_in     (w_fr),
      .u_in     (u_fr),
      .s_out    (s_pr),
      .sq_out   (sq_pr),
      .neg_out  (neg_pr),
      .zero_out (zero_pr)
   );

   // one root unit per column vector (u, w, n)
   for (genvar v = 0; v < 3; v++) begin : g_root
      frm_isqrt u_isqrt (
         .clock    (clock),
         .en       (en[ROOT0 +: frm_pkg::NSTEP]),
         .s_in     (s_pr[v]),
         .sq_in    (sq_pr[v]),
         .neg_in   (neg_pr[v]),
         .zero_in  (zero_pr[v]),
         .m_out    (m_rt[v]),
         .neg_out  (neg_rt[v]),
         .zero_out (zero_rt[v])
      );
   end

   // output stage: q = round-half-up of m / 2, sign, clamp; zero on degenerate
   frm_pkg::out_type rot_in [3][3];   // [column][row]
   frm_pkg::out_type rot_ff [3][3];
   logic             degen_in;
   logic             degen_ff;

   always_comb begin
      logic [frm_pkg::Q_W:0] qv;
      frm_pkg::val_type      sv;
      degen_in = zero_rt[0] || zero_rt[1] || zero_rt[2];
      for (int v = 0; v < 3; v++) begin
         for (int c = 0; c < 3; c++) begin
            qv = ({1'b0, m_rt[v][c]} + 1'b1) >> 1;
            sv = neg_rt[v][c] ? -frm_pkg::val_type'(qv) : frm_pkg::val_type'(qv);
            rot_in[v][c] = degen_in ? '0 : frm_pkg::sat_out(sv);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[OUT_STG]) begin
         rot_ff   <= rot_in;
         degen_ff <= degen_in;
      end
   end

   assign rsp_if.valid      = vld_ff[OUT_STG];
   assign rsp_if.rot_00     = rot_ff[0][0];
   assign rsp_if.rot_01     = rot_ff[1][0];
   assign rsp_if.rot_02     = rot_ff[2][0];
   assign rsp_if.rot_10     = rot_ff[0][1];
   assign rsp_if.rot_11     = rot_ff[1][1];
   assign rsp_if.rot_12     = rot_ff[2][1];
   assign rsp_if.rot_20     = rot_ff[0][2];
   assign rsp_if.rot_21     = rot_ff[1][2];
   assign rsp_if.rot_22     = rot_ff[2][2];
   assign rsp_if.degenerate = degen_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/frm_front.sv
// Cross products w = n x h and u = w x n over four register stages.
`timescale 1ns / 1ps
`default_nettype none
module frm_front (
   input  wire logic            clock,
   input  wire logic [3:0]      en,
   input  wire frm_pkg::in_type n_in [3],
   input  wire frm_pkg::in_type h_in [3],
   output frm_pkg::in_type      n_out [3],
   output frm_pkg::w_type       w_out [3],
   output frm_pkg::u_type       u_out [3]
);

   frm_pkg::p1_type p_in [6];
   frm_pkg::p1_type p_ff [6];
   frm_pkg::in_type n0_ff [3];

   frm_pkg::w_type  w1_in [3];
   frm_pkg::w_type  w1_ff [3];
   frm_pkg::in_type n1_ff [3];

   frm_pkg::u_type  r_in [6];
   frm_pkg::u_type  r_ff [6];
   frm_pkg::w_type  w2_ff [3];
   frm_pkg::in_type n2_ff [3];

   frm_pkg::u_type  u3_in [3];
   frm_pkg::u_type  u3_ff [3];
   frm_pkg::w_type  w3_ff [3];
   frm_pkg::in_type n3_ff [3];

   // stage 0: the six n*h products
   always_comb begin
      p_in[0] = n_in[1] * h_in[2];
      p_in[1] = n_in[2] * h_in[1];
      p_in[2] = n_in[2] * h_in[0];
      p_in[3] = n_in[0] * h_in[2];
      p_in[4] = n_in[0] * h_in[1];
      p_in[5] = n_in[1] * h_in[0];
   end

   // stage 1: w components
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         w1_in[i] = frm_pkg::w_type'(p_ff[2*i]) - frm_pkg::w_type'(p_ff[2*i+1]);
      end
   end

   // stage 2: the six w*n products
   always_comb begin
      r_in[0] = w1_ff[1] * n1_ff[2];
      r_in[1] = w1_ff[2] * n1_ff[1];
      r_in[2] = w1_ff[2] * n1_ff[0];
      r_in[3] = w1_ff[0] * n1_ff[2];
      r_in[4] = w1_ff[0] * n1_ff[1];
      r_in[5] = w1_ff[1] * n1_ff[0];
   end

   // stage 3: u components
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         u3_in[i] = r_ff[2*i] - r_ff[2*i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         p_ff  <= p_in;
         n0_ff <= n_in;
      end
      if (en[1]) begin
         w1_ff <= w1_in;
         n1_ff <= n0_ff;
      end
      if (en[2]) begin
         r_ff  <= r_in;
         w2_ff <= w1_ff;
         n2_ff <= n1_ff;
      end
      if (en[3]) begin
         u3_ff <= u3_in;
         w3_ff <= w2_ff;
         n3_ff <= n2_ff;
      end
   end

   assign n_out = n3_ff;
   assign w_out = w3_ff;
   assign u_out = u3_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/frm_prep.sv
// Magnitudes, range reduction, squares and sum of squares for the three vectors.
`timescale 1ns / 1ps
`default_nettype none
module frm_prep (
   input  wire logic            clock,
   input  wire logic [3:0]      en,
   input  wire frm_pkg::in_type n_in [3],
   input  wire frm_pkg::w_type  w_in [3],
   input  wire frm_pkg::u_type  u_in [3],
   output frm_pkg::s_type       s_out [3],
   output frm_pkg::sq_type      sq_out [3][3],
   output logic                 neg_out [3][3],
   output logic                 zero_out [3]
);

   // vector 0 is u (column 0), 1 is w (column 1), 2 is n (column 2)
   frm_pkg::u_type   vec [3][3];

   frm_pkg::mag_type mag_in [3][3];
   frm_pkg::mag_type mag_ff [3][3];
   logic             neg0_ff [3][3];

   frm_pkg::red_type red_in [3][3];
   frm_pkg::red_type red_ff [3][3];
   logic             neg1_ff [3][3];

   frm_pkg::sq_type  sq_in [3][3];
   frm_pkg::sq_type  sq2_ff [3][3];
   logic             neg2_ff [3][3];

   frm_pkg::s_type   s_in [3];
   frm_pkg::s_type   s_ff [3];
   frm_pkg::sq_type  sq3_ff [3][3];
   logic             neg3_ff [3][3];
   logic             zero_ff [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         vec[0][c] = u_in[c];
         vec[1][c] = frm_pkg::u_type'(w_in[c]);
         vec[2][c] = frm_pkg::u_type'(n_in[c]);
      end
   end

   // stage 0: magnitudes
   always_comb begin
      for (int v = 0; v < 3; v++) begin
         for (int c = 0; c < 3; c++) begin
            if (vec[v][c] < 0) begin
               mag_in[v][c] = frm_pkg::mag_type'(-vec[v][c]);
            end else begin
               mag_in[v][c] = frm_pkg::mag_type'(vec[v][c]);
            end
         end
      end
   end

   // stage 1: shift every component right until all fit in RED_W bits
   always_comb begin
      frm_pkg::mag_type orv;
      frm_pkg::sh_type  sh;
      for (int v = 0; v < 3; v++) begin
         orv = mag_ff[v][0] | mag_ff[v][1] | mag_ff[v][2];
         sh  = '0;
         for (int i = frm_pkg::RED_W; i < frm_pkg::MAG_W; i++) begin
            if (orv[i]) begin
               sh = frm_pkg::sh_type'(i - frm_pkg::RED_W + 1);
            end
         end
         for (int c = 0; c < 3; c++) begin
            red_in[v][c] = frm_pkg::red_type'(mag_ff[v][c] >> sh);
         end
      end
   end

   // stage 2: squares
   always_comb begin
      for (int v = 0; v < 3; v++) begin
         for (int c = 0; c < 3; c++) begin
            sq_in[v][c] = frm_pkg::sq_type'(red_ff[v][c]) * frm_pkg::sq_type'(red_ff[v][c]);
         end
      end
   end

   // stage 3: sum of squares
   always_comb begin
      for (int v = 0; v < 3; v++) begin
         s_in[v] = frm_pkg::s_type'(sq2_ff[v][0]) + frm_pkg::s_type'(sq2_ff[v][1])
                 + frm_pkg::s_type'(sq2_ff[v][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         mag_ff <= mag_in;
         for (int v = 0; v < 3; v++) begin
            for (int c = 0; c < 3; c++) begin
               neg0_ff[v][c] <= vec[v][c][frm_pkg::U_W-1];
            end
         end
      end
      if (en[1]) begin
         red_ff  <= red_in;
         neg1_ff <= neg0_ff;
      end
      if (en[2]) begin
         sq2_ff  <= sq_in;
         neg2_ff <= neg1_ff;
      end
      if (en[3]) begin
         s_ff    <= s_in;
         sq3_ff  <= sq2_ff;
         neg3_ff <= neg2_ff;
         for (int v = 0; v < 3; v++) begin
            zero_ff[v] <= (s_in[v] == '0);
         end
      end
   end

   assign s_out    = s_ff;
   assign sq_out   = sq3_ff;
   assign neg_out  = neg3_ff;
   assign zero_out = zero_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/frm_isqrt.sv
// Digit-per-stage search of m = floor(2^(F+1) |a| / sqrt(S)) for three lanes of one vector.
`timescale 1ns / 1ps
`default_nettype none
module frm_isqrt (
   input  wire logic                       clock,
   input  wire logic [frm_pkg::NSTEP-1:0]  en,
   input  wire frm_pkg::s_type             s_in,
   input  wire frm_pkg::sq_type            sq_in [3],
   input  wire logic                       neg_in [3],
   input  wire logic                       zero_in,
   output frm_pkg::q_type                  m_out [3],
   output logic                            neg_out [3],
   output logic                            zero_out
);

   // per lane: d = R - m^2 S (remainder), t = m S, m = digits so far
   frm_pkg::d_type d_ff   [frm_pkg::NSTEP][3];
   frm_pkg::t_type t_ff   [frm_pkg::NSTEP][3];
   frm_pkg::q_type m_ff   [frm_pkg::NSTEP][3];
   logic           neg_ff [frm_pkg::NSTEP][3];
   frm_pkg::s_type s_ff   [frm_pkg::NSTEP];
   logic           z_ff   [frm_pkg::NSTEP];

   for (genvar k = 0; k < frm_pkg::NSTEP; k++) begin : g_step
      localparam int B = frm_pkg::NSTEP - 1 - k;

      frm_pkg::d_type d_src [3];
      frm_pkg::t_type t_src [3];
      frm_pkg::q_type m_src [3];
      logic           neg_src [3];
      frm_pkg::s_type s_src;
      logic           z_src;

      frm_pkg::d_type d_in [3];
      frm_pkg::t_type t_in [3];
      frm_pkg::q_type m_in [3];

      if (k == 0) begin : g_first
         always_comb begin
            for (int c = 0; c < 3; c++) begin
               d_src[c] = frm_pkg::d_type'(sq_in[c]) << (2 * frm_pkg::FRAC_BITS + 2);
               t_src[c] = '0;
               m_src[c] = '0;
            end
            neg_src = neg_in;
            s_src   = s_in;
            z_src   = zero_in;
         end
      end else begin : g_next
         always_comb begin
            d_src   = d_ff[k-1];
            t_src   = t_ff[k-1];
            m_src   = m_ff[k-1];
            neg_src = neg_ff[k-1];
            s_src   = s_ff[k-1];
            z_src   = z_ff[k-1];
         end
      end

      // try digit 2^B: (m + 2^B)^2 S - m^2 S = 2^(B+1) t + 2^(2B) S
      always_comb begin
         frm_pkg::cmp_type cand;
         for (int c = 0; c < 3; c++) begin
            cand = (frm_pkg::cmp_type'(t_src[c]) << (B + 1))
                 + (frm_pkg::cmp_type'(s_src) << (2 * B));
            if (cand <= frm_pkg::cmp_type'(d_src[c])) begin
               d_in[c] = d_src[c] - frm_pkg::d_type'(cand);
               t_in[c] = t_src[c] + (frm_pkg::t_type'(s_src) << B);
               m_in[c] = m_src[c] | (frm_pkg::q_type'(1) << B);
            end else begin
               d_in[c] = d_src[c];
               t_in[c] = t_src[c];
               m_in[c] = m_src[c];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            d_ff[k]   <= d_in;
            t_ff[k]   <= t_in;
            m_ff[k]   <= m_in;
            neg_ff[k] <= neg_src;
            s_ff[k]   <= s_src;
            z_ff[k]   <= z_src;
         end
      end
   end

   assign m_out    = m_ff[frm_pkg::NSTEP-1];
   assign neg_out  = neg_ff[frm_pkg::NSTEP-1];
   assign zero_out = z_ff[frm_pkg::NSTEP-1];

endmodule
`default_nettype wire

FILE: hw/rtl/frm_check.sv
// Port-level checks of the frame pipeline and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module frm_check (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire frm_pkg::out_type rot_00,
   input wire frm_pkg::out_type rot_01,
   input wire frm_pkg::out_type rot_02,
   input wire frm_pkg::out_type rot_10,
   input wire frm_pkg::out_type rot_11,
   input wire frm_pkg::out_type rot_12,
   input wire frm_pkg::out_type rot_20,
   input wire frm_pkg::out_type rot_21,
   input wire frm_pkg::out_type rot_22,
   input wire logic             degenerate
);

   // pipe is empty in the cycle after reset
   a_empty_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid)
      else $error("response valid right after reset");

   // a free output means the whole pipe moves, so input must be ready
   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input stalled while output is free");

   // degenerate beats carry an all-zero matrix
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && degenerate) |->
         (rot_00 == 0 && rot_01 == 0 && rot_02 == 0 && rot_10 == 0 && rot_11 == 0 &&
          rot_12 == 0 && rot_20 == 0 && rot_21 == 0 && rot_22 == 0))
      else $error("degenerate beat with nonzero matrix");

   // a good beat has a nonzero unit normal column
   a_normal_col: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !degenerate) |-> (rot_02 != 0 || rot_12 != 0 || rot_22 != 0))
      else $error("zero normal column on non-degenerate beat");

   // stalled response holds: valid stays up and rot_00, rot_22, degenerate keep
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rot_00) && $stable(rot_22) && $stable(degenerate)))
      else $error("stalled response changed");

endmodule

bind frame_from_normal_and_heading frm_check u_frm_check (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_if.ready),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .rot_00     (rsp_if.rot_00),
   .rot_01     (rsp_if.rot_01),
   .rot_02     (rsp_if.rot_02),
   .rot_10     (rsp_if.rot_10),
   .rot_11     (rsp_if.rot_11),
   .rot_12     (rsp_if.rot_12),
   .rot_20     (rsp_if.rot_20),
   .rot_21     (rsp_if.rot_21),
   .rot_22     (rsp_if.rot_22),
   .degenerate (rsp_if.degenerate)
);
`default_nettype wire

FILE: tb/frame_from_normal_and_heading_checker.sv
// Scoreboard for the frame pipeline: predicts each rotation from the normal and heading.
`timescale 1ns / 1ps
module frame_from_normal_and_heading_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   frm_req_if                                     req_if,
   frm_rsp_if                                     rsp_if,
   input  logic                                   csr_wr_en,
   input  logic [frm_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [frm_pkg::CSR_DAT_W-1:0]          csr_wdata,
   output int                                     fail_count,
   output int                                     pending
);

   typedef struct {
      logic signed [15:0] rot [9];
      logic               degenerate;
   } frame_type;

   frame_type   frame_q [$];
   logic signed [15:0] head_x, head_y, head_z;

   initial begin
      fail_count = 0;
   end

   assign pending = frame_q.size();

   task automatic report(input string what, input int got, input int want);
      $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   // scale v to unit length, Q with FRAC_BITS, round half away from zero
   function automatic bit unit_vec(input longint v [3], output longint o [3]);
      logic [63:0]  m [3];
      logic [127:0] s, rhs, lhs, t;
      longint       lo, hi, mid;
      s = 0;
      for (int i = 0; i < 3; i++) m[i] = v[i] < 0 ? -v[i] : v[i];
      while (m[0] >= 64'h8000_0000 || m[1] >= 64'h8000_0000 || m[2] >= 64'h8000_0000)
         for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      for (int i = 0; i < 3; i++) s += 128'(m[i]) * 128'(m[i]);
      if (s == 0) return 0;
      for (int i = 0; i < 3; i++) begin
         rhs = (128'(1) << (2 * frm_pkg::FRAC_BITS + 2)) * (128'(m[i]) * 128'(m[i]));
         lo = 0;
         hi = longint'(1) << frm_pkg::FRAC_BITS;
         while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            t = 128'(2 * mid - 1);
            lhs = t * t * s;
            if (lhs <= rhs) lo = mid;
            else hi = mid - 1;
         end
         o[i] = v[i] < 0 ? -lo : lo;
      end
      return 1;
   endfunction

   function automatic frame_type predict_frame(input longint nx, ny, nz,
                                               input longint hx, hy, hz);
      frame_type f;
      longint n [3], w [3], u [3], c0 [3], c1 [3], c2 [3];
      longint e;
      n = '{nx, ny, nz};
      w[0] = ny * hz - nz * hy;
      w[1] = nz * hx - nx * hz;
      w[2] = nx * hy - ny * hx;
      u[0] = w[1] * nz - w[2] * ny;
      u[1] = w[2] * nx - w[0] * nz;
      u[2] = w[0] * ny - w[1] * nx;
      f.degenerate = 1'b1;
      for (int i = 0; i < 9; i++) f.rot[i] = '0;
      if (unit_vec(n, c2) && unit_vec(w, c1) && unit_vec(u, c0)) begin
         f.degenerate = 1'b0;
         for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++) begin
               e = c == 0 ? c0[r] : c == 1 ? c1[r] : c2[r];
               if (e > 32767) e = 32767;
               if (e < -32768) e = -32768;
               f.rot[r * 3 + c] = e[15:0];
            end
      end
      return f;
   endfunction

   always @(posedge clock) begin
      frame_type want;
      logic signed [15:0] got [9];
      if (reset) begin
         head_x <= frm_pkg::HEADING_X_RST;
         head_y <= frm_pkg::HEADING_Y_RST;
         head_z <= frm_pkg::HEADING_Z_RST;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               frm_pkg::REG_HEADING_X: head_x <= csr_wdata;
               frm_pkg::REG_HEADING_Y: head_y <= csr_wdata;
               frm_pkg::REG_HEADING_Z: head_z <= csr_wdata;
               default: ;
            endcase
         end
         if (req_if.valid && req_if.ready)
            frame_q.push_back(predict_frame(req_if.nrm_x, req_if.nrm_y,
                                            req_if.nrm_z, head_x, head_y, head_z));
         if (rsp_if.valid && rsp_if.ready) begin
            if (frame_q.size() == 0) begin
               report("unexpected beat", 1, 0);
            end else begin
               want = frame_q.pop_front();
               got = '{rsp_if.rot_00, rsp_if.rot_01, rsp_if.rot_02,
                       rsp_if.rot_10, rsp_if.rot_11, rsp_if.rot_12,
                       rsp_if.rot_20, rsp_if.rot_21, rsp_if.rot_22};
               for (int i = 0; i < 9; i++)
                  if (got[i] !== want.rot[i])
                     report($sformatf("rot_%0d%0d", i / 3, i % 3), got[i], want.rot[i]);
               if (rsp_if.degenerate !== want.degenerate)
                  report("degenerate", rsp_if.degenerate, want.degenerate);
            end
         end
      end
   end
endmodule

FILE: tb/frame_from_normal_and_heading_tb.sv
// Testbench top: normal stimulus, heading programming, back-pressure and verdict.
`timescale 1ns / 1ps
module frame_from_normal_and_heading_tb;

   // index 3 decodes to no register; a write there must change nothing
   localparam logic [frm_pkg::CSR_IDX_W-1:0] REG_NONE = 2'd3;
   localparam int PIPE_LAT = frm_pkg::FRAC_BITS + 11;

   logic clock = 0;
   logic reset = 1;
   logic                          csr_wr_en = 0;
   logic [frm_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [frm_pkg::CSR_DAT_W-1:0] csr_wdata = '0;
   int   fail_count, pending;
   bit   quiet = 0;            // no idling on either side
   int   hold_seq = 0;         // bump to make the receiver hold off
   int   hold_seen = 0;
   int   hold_left = 0;
   logic signed [15:0] hx = 16384, hy = 0, hz = 0;   // current heading

   frm_req_if req_if ();
   frm_rsp_if rsp_if ();

   frame_from_normal_and_heading DUT (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata));

   frame_from_normal_and_heading_checker checker_i (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending));

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   initial begin
      req_if.valid = 0;
      req_if.nrm_x = '0;
      req_if.nrm_y = '0;
      req_if.nrm_z = '0;
      rsp_if.ready = 0;
   end

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen <= hold_seq;
         hold_left <= 300;
         rsp_if.ready <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_if.ready <= 0;
      end else begin
         rsp_if.ready <= quiet || $urandom_range(99) >= 6;
      end
   end

   // hard stop
   initial begin
      #3ms;
      $display("Some tests failed");
      $finish;
   end

   // one register write per cycle; the caller drops the enable after the last
   task automatic write_reg(input logic [frm_pkg::CSR_IDX_W-1:0] idx,
                            input logic [15:0] val);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // program the heading once the pipe has drained
   task automatic set_heading(input logic [15:0] x, y, z);
      wait (pending == 0);
      @(posedge clock);
      write_reg(frm_pkg::REG_HEADING_X, x);
      write_reg(frm_pkg::REG_HEADING_Y, y);
      write_reg(frm_pkg::REG_HEADING_Z, z);
      write_reg(REG_NONE, 16'($urandom));
      csr_wr_en <= 0;
      hx = x;
      hy = y;
      hz = z;
   endtask

   // one beat; valid stays up between back-to-back beats
   task automatic send_normal(input logic [15:0] x, y, z);
      req_if.valid <= 1;
      req_if.nrm_x <= x;
      req_if.nrm_y <= y;
      req_if.nrm_z <= z;
      do @(posedge clock); while (!req_if.ready);
      if (!quiet && $urandom_range(99) < 6) begin
         req_if.valid <= 0;
         @(posedge clock);
      end
   endtask

   // random normal: mostly full range, some tiny, some along the heading
   task automatic send_random();
      int k;
      logic signed [15:0] s;
      k = $urandom_range(19);
      s = $urandom_range(1) ? 16'sd1 : -16'sd1;
      if (k < 2)
         send_normal(hx * s, hy * s, hz * s);
      else if (k < 4)
         send_normal(16'($urandom_range(6) - 3), 16'($urandom_range(6) - 3),
                     16'($urandom_range(6) - 3));
      else if (k == 4)
         send_normal(16'(16'h8000 | $urandom_range(3)), 16'($urandom),
                     16'(16'h7FFF - $urandom_range(3)));
      else
         send_normal(16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed, reset heading (1, 0, 0)
      send_normal(0, 0, 0);                   // zero normal
      send_normal(16384, 0, 0);               // parallel to heading
      send_normal(-16384, 0, 0);              // anti-parallel
      send_normal(16'h8000, 0, 0);
      send_normal(0, 16384, 0);
      send_normal(0, 0, 16384);
      send_normal(0, 0, 1);
      send_normal(1, 1, 1);
      send_normal(16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_normal(16'h8000, 16'h8000, 16'h8000);
      send_normal(16'h7FFF, 16'h8000, 16'h7FFF);
      send_normal(16'h8000, 16'h7FFF, 0);
      send_normal(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_normal(11585, 11585, 0);
      send_normal(-16384, 16384, -16384);
      send_normal(3, 0, 16'h8000);

      // heading extremes, then random headings
      for (int ph = 0; ph < 8; ph++) begin
         req_if.valid <= 0;
         case (ph)
            0: set_heading(16'h7FFF, 16'h7FFF, 16'h7FFF);
            1: set_heading(16'h8000, 16'h8000, 16'h8000);
            2: set_heading(0, 0, 0);          // zero heading: all degenerate
            3: set_heading(16'h8000, 0, 16'h7FFF);
            4: set_heading(0, 1, 0);
            default: set_heading(16'($urandom), 16'($urandom), 16'($urandom));
         endcase
         quiet = (ph == 5);
         for (int i = 0; i < (ph == 2 ? 40 : 230); i++) begin
            if (ph == 3 && i == 20) hold_seq++;      // fill the pipe
            if (ph == 4 && i == 100) begin           // drain fully mid-phase
               req_if.valid <= 0;
               wait (pending == 0);
               @(posedge clock);
            end
            send_random();
         end
      end
      quiet = 0;
      req_if.valid <= 0;

      wait (pending == 0);
      repeat (PIPE_LAT + 15) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule
